[rtl/epit_pkg.sv]
package epit_pkg;

  // Table and field sizes.
  localparam int MAX_X_TYPES   = 16;
  localparam int MAX_Y_TYPES   = 16;
  localparam int STAMP_BITS    = 32;
  localparam int COUNT_BITS    = 32;
  localparam int TYPE_BITS     = 4;
  localparam int TCNT_BITS     = 5;
  localparam int CODE_BITS     = 8;
  localparam int INTERVAL_BITS = 33;
  localparam int PAIR_SLOTS    = MAX_X_TYPES * MAX_Y_TYPES;

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = TCNT_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_X_TYPE_COUNT = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_Y_TYPE_COUNT = CFG_IDX_BITS'(1);
  localparam logic [TCNT_BITS-1:0] TYPE_COUNT_RESET = TCNT_BITS'(16);

  // Output queue.
  localparam int OUT_DEPTH     = 4;
  localparam int OUT_PTR_BITS  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS  = $clog2(OUT_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic [CODE_BITS-1:0] code_t;

  // One result transaction.
  typedef struct packed {
    logic signed [INTERVAL_BITS-1:0] interval;
    logic [CODE_BITS-1:0]            pair_code;
    logic [COUNT_BITS-1:0]           pair_count;
  } result_t;

  // Counter update request from the event front end.
  typedef struct packed {
    logic                            valid;
    code_t                           code;
    logic signed [INTERVAL_BITS-1:0] interval;
  } cnt_req_t;

endpackage

[rtl/epit_if.sv]
interface epit_evt_if import epit_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  x_valid;
  logic [TYPE_BITS-1:0]  x_type;
  logic                  y_valid;
  logic [TYPE_BITS-1:0]  y_type;
  logic                  is_break;
  logic [STAMP_BITS-1:0] stamp;

  modport source (output valid, x_valid, x_type, y_valid, y_type, is_break, stamp,
                  input ready);
  modport sink (input valid, x_valid, x_type, y_valid, y_type, is_break, stamp,
                output ready);
endinterface

interface epit_res_if import epit_pkg::*; ();
  logic                            valid;
  logic                            ready;
  logic signed [INTERVAL_BITS-1:0] interval;
  logic [CODE_BITS-1:0]            pair_code;
  logic [COUNT_BITS-1:0]           pair_count;

  modport source (output valid, interval, pair_code, pair_count, input ready);
  modport sink (input valid, interval, pair_code, pair_count, output ready);
endinterface

interface epit_cfg_if import epit_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/epit_ram.sv]
module epit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual port; a read at the written address returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/epit_cnt.sv]
module epit_cnt import epit_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cnt_req_t req,
  output logic     res_valid,
  output result_t  res
);

  logic                            s1_valid;
  code_t                           s1_code;
  logic signed [INTERVAL_BITS-1:0] s1_interval;
  logic                            rd_valid;
  logic                            fwd_hit;
  logic [COUNT_BITS-1:0]           fwd_data;
  logic [COUNT_BITS-1:0]           rdata;
  logic [COUNT_BITS-1:0]           base;
  logic [COUNT_BITS-1:0]           count_next;
  logic [PAIR_SLOTS-1:0]           written;

  // Pair counters; read on request, written back in the next cycle.
  epit_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (PAIR_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_code),
    .wdata (count_next),
    .raddr (req.code),
    .rdata (rdata)
  );

  // Old count: the value written in the previous cycle wins over the memory,
  // and an entry never written since reset reads as zero.
  always_comb begin
    base       = fwd_hit ? fwd_data : (rd_valid ? rdata : '0);
    count_next = (base == COUNT_MAX) ? base : base + 1'b1;
  end

  // Control state and per-entry written flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      written  <= '0;
    end else begin
      s1_valid <= req.valid;
      if (s1_valid) begin
        written[s1_code] <= 1'b1;
      end
    end
  end

  // Request payload and forwarding capture.
  always_ff @(posedge clk) begin
    if (req.valid) begin
      s1_code     <= req.code;
      s1_interval <= req.interval;
      rd_valid    <= written[req.code];
      fwd_hit     <= s1_valid && (s1_code == req.code);
      fwd_data    <= count_next;
    end
  end

  assign res_valid      = s1_valid;
  assign res.interval   = s1_interval;
  assign res.pair_code  = s1_code;
  assign res.pair_count = count_next;

endmodule

[rtl/epit_fifo.sv]
module epit_fifo import epit_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  result_t                 push_data,
  input  logic                    pop,
  output logic                    valid,
  output result_t                 data,
  output logic [OUT_CNT_BITS-1:0] count
);

  result_t                 mem [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] wr_ptr;
  logic [OUT_PTR_BITS-1:0] rd_ptr;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OUT_CNT_BITS'(push) - OUT_CNT_BITS'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

endmodule

[rtl/event_pair_interval_tracker_top.sv]
// Each result passes the counter stage, then the result queue, before res.
// Throughput: one event per cycle while the result queue has room, set by the
// pair counter memory, which is read on acceptance and written back in the next
// cycle with forwarding. Events that cause no result produce nothing.
// Reset (rst, synchronous, active high) drops the held X event, marks all
// pair counters as zero through per-entry flags and sets both type counts to 16.
module event_pair_interval_tracker_top import epit_pkg::*; (
  input logic clk,
  input logic rst,
  epit_cfg_if.sink   cfg,
  epit_evt_if.sink   evt,
  epit_res_if.source res
);

  logic [TCNT_BITS-1:0]            x_type_count;
  logic [TCNT_BITS-1:0]            y_type_count;
  logic                            holding_x;
  logic                            holding_x_next;
  logic [TYPE_BITS-1:0]            held_x_type;
  logic [STAMP_BITS-1:0]           held_x_stamp;
  logic                            accept;
  logic                            x_hit;
  logic                            y_hit;
  logic [TCNT_BITS-1:0]            ny_eff;
  logic [CODE_BITS:0]              code_wide;
  cnt_req_t                        req;
  logic                            s1_valid;
  result_t                         s1_res;
  result_t                         out_data;
  logic                            out_valid;
  logic [OUT_CNT_BITS-1:0]         out_count;
  logic [OUT_CNT_BITS-1:0]         in_flight;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_type_count <= TYPE_COUNT_RESET;
      y_type_count <= TYPE_COUNT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_X_TYPE_COUNT: x_type_count <= cfg.data;
        REG_Y_TYPE_COUNT: y_type_count <= cfg.data;
        default: ;
      endcase
    end
  end

  // Room for this event's result, counting the one still in the counter stage.
  assign in_flight = out_count + OUT_CNT_BITS'(s1_valid);
  assign evt.ready = (in_flight < OUT_CNT_BITS'(OUT_DEPTH));
  assign accept    = evt.valid && evt.ready;

  // Type match and pair code.
  always_comb begin
    x_hit     = evt.x_valid && ({1'b0, evt.x_type} < x_type_count);
    y_hit     = evt.y_valid && ({1'b0, evt.y_type} < y_type_count);
    ny_eff    = (y_type_count > TCNT_BITS'(MAX_Y_TYPES)) ?
                TCNT_BITS'(MAX_Y_TYPES) : y_type_count;
    code_wide = (CODE_BITS+1)'(held_x_type) * (CODE_BITS+1)'(ny_eff)
                + (CODE_BITS+1)'(evt.y_type);
  end

  // Held X update: a Y closes the pair, an X re-arms, a break then drops it.
  always_comb begin
    holding_x_next = holding_x;
    if (!holding_x) begin
      holding_x_next = x_hit;
    end else begin
      if (y_hit) begin
        holding_x_next = 1'b0;
      end
      if (x_hit) begin
        holding_x_next = 1'b1;
      end
      if (evt.is_break) begin
        holding_x_next = 1'b0;
      end
    end
  end

  always_comb begin
    req.valid    = accept && holding_x && y_hit;
    req.code     = code_wide[CODE_BITS-1:0];
    req.interval = {1'b0, evt.stamp} - {1'b0, held_x_stamp};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding_x <= 1'b0;
    end else if (accept) begin
      holding_x <= holding_x_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && x_hit) begin
      held_x_type  <= evt.x_type;
      held_x_stamp <= evt.stamp;
    end
  end

  // Pair counter read-modify-write.
  epit_cnt u_cnt (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (s1_valid),
    .res       (s1_res)
  );

  // Result queue toward the output channel.
  epit_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (s1_res),
    .pop       (res.valid && res.ready),
    .valid     (out_valid),
    .data      (out_data),
    .count     (out_count)
  );

  assign res.valid      = out_valid;
  assign res.interval   = out_data.interval;
  assign res.pair_code  = out_data.pair_code;
  assign res.pair_count = out_data.pair_count;

endmodule

[rtl/epit_chk.sv]
module epit_chk import epit_pkg::*; (
  input logic                            clk,
  input logic                            rst,
  input logic                            evt_ready,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic signed [INTERVAL_BITS-1:0] res_interval,
  input logic [CODE_BITS-1:0]            res_pair_code,
  input logic [COUNT_BITS-1:0]           res_pair_count
);

  // Reset empties the result path.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_interval)
      && $stable(res_pair_code) && $stable(res_pair_count))
    else $error("stalled result changed");

  // Events are refused only while results are waiting.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !evt_ready |-> res_valid)
    else $error("event input stalled with no result waiting");

  // Every reported pair has occurred at least once.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_pair_count != '0)
    else $error("result carries a zero pair count");

endmodule

bind event_pair_interval_tracker_top epit_chk u_chk (
  .clk            (clk),
  .rst            (rst),
  .evt_ready      (evt.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_interval   (res.interval),
  .res_pair_code  (res.pair_code),
  .res_pair_count (res.pair_count)
);
